// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the seat pressure relief controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define SPRC_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define SPRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sprc_pkg.sv =====
// Types, codes and constants of the seat pressure relief controller.
package sprc_pkg;

  localparam int ADC_W     = 10;
  localparam int MS_W      = 32;
  localparam int MIN_W     = 17;
  localparam int MIN_MS_W  = 24;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_LANES = 6;

  typedef logic [ADC_W-1:0]     adc_t;
  typedef logic [MS_W-1:0]      ms_t;
  typedef logic [MIN_W-1:0]     minutes_t;
  typedef logic [MIN_MS_W-1:0]  min_ms_t;
  typedef logic [CFG_W-1:0]     cfg_data_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [7:0]           min_cnt_t;
  typedef logic [15:0]          ms16_t;
  typedef logic [1:0]           mode_t;

  // Operating modes.
  localparam mode_t MODE_IDLE    = 2'd0;
  localparam mode_t MODE_NORMAL  = 2'd1;
  localparam mode_t MODE_WARNING = 2'd2;
  localparam mode_t MODE_DANGER  = 2'd3;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_SIT_THR   = 3'd0;
  localparam cfg_idx_t CFG_IDLE_THR  = 3'd1;
  localparam cfg_idx_t CFG_TARGET    = 3'd2;
  localparam cfg_idx_t CFG_WARN_MIN  = 3'd3;
  localparam cfg_idx_t CFG_DANGER_MIN = 3'd4;
  localparam cfg_idx_t CFG_VENT_MS   = 3'd5;
  localparam cfg_idx_t CFG_BUZZ_MS   = 3'd6;

  // Register reset values.
  localparam adc_t     RST_SIT_THR    = 10'd273;
  localparam adc_t     RST_IDLE_THR   = 10'd597;
  localparam adc_t     RST_TARGET     = 10'd109;
  localparam min_cnt_t RST_WARN_MIN   = 8'd1;
  localparam min_cnt_t RST_DANGER_MIN = 8'd4;
  localparam ms16_t    RST_VENT_MS    = 16'd5000;
  localparam ms16_t    RST_BUZZ_MS    = 16'd500;

  // Milliseconds per minute, and its split into 2^PRE_SHIFT * 1875.
  localparam ms16_t MS_PER_MIN = 16'd60000;
  localparam int    PRE_SHIFT  = 5;
  localparam int    RECIP_SHIFT = 38;
  localparam int    RECIP_W    = 28;
  // floor(2^38 / 1875); the quotient it gives is low by at most one.
  localparam logic [RECIP_W-1:0] RECIP = 28'd146601550;

  // Per-lane compare results.
  typedef struct packed {
    logic sit;
    logic busy;
  } lane_flags_t;

  // Actuator command of one sample period.
  typedef struct packed {
    mode_t mode;
    logic  pump;
    logic  valve;
    logic  buzz;
  } act_t;

  // Controller result for one accepted beat.
  typedef struct packed {
    act_t act;
    ms_t  diff;
  } ctrl_res_t;

endpackage

// ===== rtl/sprc_sample_if.sv =====
// Input channel carrying one sample period of sensor readings.
interface sprc_sample_if;
  import sprc_pkg::*;

  logic valid;
  logic ready;
  adc_t force_a;
  adc_t force_b;
  adc_t force_c;
  adc_t force_d;
  adc_t force_e;
  adc_t force_f;
  adc_t pressure_reading;
  ms_t  now_ms;

  modport source (
    output valid, force_a, force_b, force_c, force_d, force_e, force_f,
           pressure_reading, now_ms,
    input  ready
  );

  modport sink (
    input  valid, force_a, force_b, force_c, force_d, force_e, force_f,
           pressure_reading, now_ms,
    output ready
  );
endinterface

// ===== rtl/sprc_status_if.sv =====
// Output channel carrying the controller status of one sample period.
interface sprc_status_if;
  import sprc_pkg::*;

  logic     valid;
  logic     ready;
  mode_t    mode;
  logic     pump_on;
  logic     valve_open;
  logic     buzzer_on;
  minutes_t sit_minutes;
  adc_t     peak_force;

  modport source (
    output valid, mode, pump_on, valve_open, buzzer_on, sit_minutes, peak_force,
    input  ready
  );

  modport sink (
    input  valid, mode, pump_on, valve_open, buzzer_on, sit_minutes, peak_force,
    output ready
  );
endinterface

// ===== rtl/sprc_lane.sv =====
// One force lane: compares a single sensor reading against both thresholds.
module sprc_lane (
  input  sprc_pkg::adc_t        force_val,
  input  sprc_pkg::adc_t        sit_thr,
  input  sprc_pkg::adc_t        idle_thr,
  output sprc_pkg::lane_flags_t flags
);
  import sprc_pkg::*;

  // The peak reaches a threshold exactly when some lane does.
  assign flags.sit  = (force_val >= sit_thr);
  assign flags.busy = (force_val >= idle_thr);
endmodule

// ===== rtl/sprc_peak.sv =====
// Registered two-level maximum tree over the force lanes.
module sprc_peak (
  input  logic           clk,
  input  logic           adv,
  input  sprc_pkg::adc_t force_vec [sprc_pkg::NUM_LANES],
  output sprc_pkg::adc_t peak
);
  import sprc_pkg::*;

  localparam int PAIRS = NUM_LANES / 2;

  adc_t pair_max [PAIRS];
  adc_t pair_best;

  // First level: maximum of each lane pair.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < PAIRS; i++) begin
        pair_max[i] <= (force_vec[2*i+1] > force_vec[2*i]) ?
                       force_vec[2*i+1] : force_vec[2*i];
      end
    end
  end

  // Second level: maximum over the pair results.
  always_comb begin
    pair_best = pair_max[0];
    for (int i = 1; i < PAIRS; i++) begin
      if (pair_max[i] > pair_best) begin
        pair_best = pair_max[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      peak <= pair_best;
    end
  end
endmodule

// ===== rtl/sprc_minutes.sv =====
// Three-stage divide of the sitting time by one minute of milliseconds.
module sprc_minutes (
  input  logic               clk,
  input  logic               adv,
  input  sprc_pkg::ms_t      diff,
  output sprc_pkg::minutes_t minutes
);
  import sprc_pkg::*;

  localparam int PROD_W = (MS_W - PRE_SHIFT) + RECIP_W;

  logic [PROD_W-1:0] recip_prod;
  minutes_t          q_est;
  ms_t               diff2;
  minutes_t          q3;
  ms_t               diff3;
  ms_t               back_prod;
  ms_t               rem;

  // Estimate: (diff / 32) times the reciprocal of 1875.
  assign recip_prod = PROD_W'(diff[MS_W-1:PRE_SHIFT]) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (adv) begin
      q_est <= recip_prod[RECIP_SHIFT +: MIN_W];
      diff2 <= diff;
    end
  end

  // Multiply the estimate back; it never exceeds the true quotient.
  always_ff @(posedge clk) begin
    if (adv) begin
      back_prod <= MS_W'(ms_t'(q_est) * ms_t'(MS_PER_MIN));
      q3        <= q_est;
      diff3     <= diff2;
    end
  end

  // The estimate is low by at most one, so one compare corrects it.
  assign rem = diff3 - back_prod;

  always_ff @(posedge clk) begin
    if (adv) begin
      minutes <= q3 + MIN_W'(rem >= ms_t'(MS_PER_MIN));
    end
  end
endmodule

// ===== rtl/sprc_ctrl.sv =====
// Configuration registers, sitting timer, mode classifier and actuator logic.
`include "assert_macros.svh"

module sprc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic                  cfg_we,
  input  sprc_pkg::cfg_idx_t    cfg_index,
  input  sprc_pkg::cfg_data_t   cfg_data,
  input  sprc_pkg::lane_flags_t lane_flags [sprc_pkg::NUM_LANES],
  input  sprc_pkg::adc_t        pressure,
  input  sprc_pkg::ms_t         now,
  output sprc_pkg::adc_t        sit_thr,
  output sprc_pkg::adc_t        idle_thr,
  output sprc_pkg::ctrl_res_t   res
);
  import sprc_pkg::*;

  adc_t    target_pressure;
  min_ms_t warning_ms;
  min_ms_t danger_ms;
  ms16_t   vent_time_ms;
  ms16_t   buzz_interval_ms;

  logic  is_sitting;
  ms_t   sit_start;
  mode_t cur_mode;
  logic  buzz_phase;
  ms_t   buzz_stamp;
  logic  danger_phase;
  ms_t   danger_stamp;
  logic  buzz_latch;

  logic  is_sitting_next;
  ms_t   sit_start_next;
  mode_t mode_next;
  logic  buzz_phase_next;
  ms_t   buzz_stamp_next;
  logic  danger_phase_next;
  ms_t   danger_stamp_next;
  logic  buzz_latch_next;

  logic  sitting_now;
  logic  not_idle;
  ms_t   diff;
  logic  entering;
  logic  phase_eff;
  ms_t   vent_elapsed;
  logic  buzz_due;
  logic  low_pressure;
  logic  pump;
  logic  valve;

  // Configuration writes; minute thresholds are stored in milliseconds.
  always_ff @(posedge clk) begin
    if (rst) begin
      sit_thr          <= RST_SIT_THR;
      idle_thr         <= RST_IDLE_THR;
      target_pressure  <= RST_TARGET;
      warning_ms       <= min_ms_t'(RST_WARN_MIN) * min_ms_t'(MS_PER_MIN);
      danger_ms        <= min_ms_t'(RST_DANGER_MIN) * min_ms_t'(MS_PER_MIN);
      vent_time_ms     <= RST_VENT_MS;
      buzz_interval_ms <= RST_BUZZ_MS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SIT_THR:    sit_thr         <= cfg_data[ADC_W-1:0];
        CFG_IDLE_THR:   idle_thr        <= cfg_data[ADC_W-1:0];
        CFG_TARGET:     target_pressure <= cfg_data[ADC_W-1:0];
        CFG_WARN_MIN: begin
          warning_ms <= min_ms_t'(cfg_data[7:0]) * min_ms_t'(MS_PER_MIN);
        end
        CFG_DANGER_MIN: begin
          danger_ms <= min_ms_t'(cfg_data[7:0]) * min_ms_t'(MS_PER_MIN);
        end
        CFG_VENT_MS:    vent_time_ms     <= cfg_data;
        CFG_BUZZ_MS:    buzz_interval_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Merge the lane flags: any lane at a threshold means the peak is too.
  always_comb begin
    sitting_now = 1'b0;
    not_idle    = 1'b0;
    for (int i = 0; i < NUM_LANES; i++) begin
      sitting_now = sitting_now | lane_flags[i].sit;
      not_idle    = not_idle | lane_flags[i].busy;
    end
  end

  // Sitting time; zero on the first sitting beat and whenever not sitting.
  assign diff = (sitting_now && is_sitting) ? (now - sit_start) : '0;

  // Mode classification, danger tested before warning.
  always_comb begin
    if (!not_idle) begin
      mode_next = MODE_IDLE;
    end else if (sitting_now && (diff >= ms_t'(danger_ms))) begin
      mode_next = MODE_DANGER;
    end else if (sitting_now && (diff >= ms_t'(warning_ms))) begin
      mode_next = MODE_WARNING;
    end else begin
      mode_next = MODE_NORMAL;
    end
  end

  assign entering     = (mode_next == MODE_DANGER) && (cur_mode != MODE_DANGER);
  assign phase_eff    = entering ? 1'b0 : danger_phase;
  assign vent_elapsed = entering ? '0 : (now - danger_stamp);
  assign buzz_due     = (now - buzz_stamp) >= ms_t'(buzz_interval_ms);
  assign low_pressure = (pressure < target_pressure);

  // Buzzer, pump, valve and danger phase for this beat.
  always_comb begin
    is_sitting_next   = sitting_now;
    sit_start_next    = (sitting_now && !is_sitting) ? now : sit_start;
    buzz_phase_next   = buzz_phase;
    buzz_stamp_next   = buzz_stamp;
    buzz_latch_next   = buzz_latch;
    danger_phase_next = phase_eff;
    danger_stamp_next = entering ? now : danger_stamp;
    pump              = 1'b0;
    valve             = 1'b0;
    case (mode_next)
      MODE_WARNING: begin
        pump = low_pressure;
        if (buzz_due) begin
          buzz_stamp_next = now;
          buzz_phase_next = !buzz_phase;
          buzz_latch_next = !buzz_phase;
        end
      end
      MODE_DANGER: begin
        buzz_latch_next = 1'b1;
        if (!phase_eff) begin
          valve = 1'b1;
          if (vent_elapsed >= ms_t'(vent_time_ms)) begin
            danger_phase_next = 1'b1;
            danger_stamp_next = now;
          end
        end else if (low_pressure) begin
          pump = 1'b1;
        end else begin
          danger_phase_next = 1'b0;
          danger_stamp_next = now;
        end
      end
      default: begin
        buzz_latch_next = 1'b0;
      end
    endcase
  end

  // Controller state advances on each accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      is_sitting   <= 1'b0;
      sit_start    <= '0;
      cur_mode     <= MODE_IDLE;
      buzz_phase   <= 1'b0;
      buzz_stamp   <= '0;
      danger_phase <= 1'b0;
      danger_stamp <= '0;
      buzz_latch   <= 1'b0;
    end else if (fire) begin
      is_sitting   <= is_sitting_next;
      sit_start    <= sit_start_next;
      cur_mode     <= mode_next;
      buzz_phase   <= buzz_phase_next;
      buzz_stamp   <= buzz_stamp_next;
      danger_phase <= danger_phase_next;
      danger_stamp <= danger_stamp_next;
      buzz_latch   <= buzz_latch_next;
    end
  end

  assign res.act.mode  = mode_next;
  assign res.act.pump  = pump;
  assign res.act.valve = valve;
  assign res.act.buzz  = buzz_latch_next;
  assign res.diff      = diff;

  `SPRC_ASSERT(a_pump_valve_excl, fire, !(pump && valve), "pump and valve both on")
  `SPRC_ASSERT(a_valve_danger, fire && valve, mode_next == MODE_DANGER, "valve outside danger")
  `SPRC_ASSERT(a_enter_vents, fire && entering, valve && !pump, "danger entry not venting")
  `SPRC_ASSERT_NEXT(a_danger_thr, !rst && cfg_we && (cfg_index == CFG_DANGER_MIN), danger_ms == min_ms_t'($past(cfg_data[7:0])) * min_ms_t'(MS_PER_MIN), "danger threshold not updated")
endmodule

// ===== rtl/seat_pressure_relief_controller.sv =====
// Four register stages; a status beat is valid once its sample beat has reached
// the fourth stage, the output register.
// Throughput: one sample beat per cycle; the whole pipeline advances together
// and stalls only while the output register holds a beat that is not taken.
// The division of sitting time by one minute takes three pipeline stages.
// Reset (synchronous) restores register defaults, clears control state, keeps ready low.
module seat_pressure_relief_controller (
  input  logic                clk,
  input  logic                rst,
  sprc_sample_if.sink         sensor,
  sprc_status_if.source       status,
  input  logic                cfg_we,
  input  sprc_pkg::cfg_idx_t  cfg_index,
  input  sprc_pkg::cfg_data_t cfg_data
);
  import sprc_pkg::*;

  logic        adv;
  logic        fire;
  logic [3:0]  stage_valid;
  adc_t        force_vec [NUM_LANES];
  lane_flags_t lane_flags [NUM_LANES];
  adc_t        sit_thr;
  adc_t        idle_thr;
  ctrl_res_t   res;
  act_t        act_s1;
  act_t        act_s2;
  act_t        act_s3;
  act_t        act_s4;
  ms_t         diff_s1;
  adc_t        peak_s2;
  adc_t        peak_s3;
  adc_t        peak_s4;
  minutes_t    minutes_s4;

  // Pipeline advances whenever the output register is free or being taken.
  assign adv          = !stage_valid[3] || status.ready;
  assign sensor.ready = adv && !rst;
  assign fire         = sensor.valid && sensor.ready;

  assign force_vec[0] = sensor.force_a;
  assign force_vec[1] = sensor.force_b;
  assign force_vec[2] = sensor.force_c;
  assign force_vec[3] = sensor.force_d;
  assign force_vec[4] = sensor.force_e;
  assign force_vec[5] = sensor.force_f;

  // Force lanes.
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    sprc_lane u_lane (
      .force_val (force_vec[g]),
      .sit_thr   (sit_thr),
      .idle_thr  (idle_thr),
      .flags     (lane_flags[g])
    );
  end

  sprc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .lane_flags (lane_flags),
    .pressure   (sensor.pressure_reading),
    .now        (sensor.now_ms),
    .sit_thr    (sit_thr),
    .idle_thr   (idle_thr),
    .res        (res)
  );

  sprc_peak u_peak (
    .clk       (clk),
    .adv       (adv),
    .force_vec (force_vec),
    .peak      (peak_s2)
  );

  sprc_minutes u_minutes (
    .clk     (clk),
    .adv     (adv),
    .diff    (diff_s1),
    .minutes (minutes_s4)
  );

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else if (adv) begin
      stage_valid <= {stage_valid[2:0], fire};
    end
  end

  // Actuator and peak delay line aligned with the divide pipeline.
  always_ff @(posedge clk) begin
    if (adv) begin
      act_s1  <= res.act;
      diff_s1 <= res.diff;
      act_s2  <= act_s1;
      act_s3  <= act_s2;
      act_s4  <= act_s3;
      peak_s3 <= peak_s2;
      peak_s4 <= peak_s3;
    end
  end

  assign status.valid       = stage_valid[3];
  assign status.mode        = act_s4.mode;
  assign status.pump_on     = act_s4.pump;
  assign status.valve_open  = act_s4.valve;
  assign status.buzzer_on   = act_s4.buzz;
  assign status.sit_minutes = minutes_s4;
  assign status.peak_force  = peak_s4;
endmodule

// ===== verif/tb_seat_pressure_relief_controller.sv =====
// Self-checking testbench of the seat pressure relief controller.
module tb_seat_pressure_relief_controller;
  import sprc_pkg::*;

  // The one index of the configuration port that addresses no register.
  localparam cfg_idx_t CFG_UNUSED = 3'd7;
  localparam int unsigned MS_PER_MINUTE = 60000;

  // One sample period as the sensor channel carries it.
  typedef struct packed {
    adc_t [5:0] lane;
    adc_t       pressure;
    ms_t        now;
  } reading_t;

  // One status beat as the status channel carries it.
  typedef struct packed {
    mode_t    mode;
    logic     pump;
    logic     valve;
    logic     buzz;
    minutes_t minutes;
    adc_t     peak;
  } status_t;

  // Tracks controller state, predicts each status beat and checks what arrives.
  class relief_status_tracker;
    adc_t     sit_thr, idle_thr, target;
    min_cnt_t warn_min, danger_min;
    ms16_t    vent_ms, buzz_ms;

    bit    seated;
    ms_t   seat_start;
    mode_t cur_mode;
    bit    buzz_phase;
    ms_t   buzz_stamp;
    bit    refilling;
    ms_t   danger_stamp;
    bit    buzz_latch;

    status_t     status_due[$];
    int unsigned beats_seen;
    int unsigned failures;

    function new();
      sit_thr      = RST_SIT_THR;
      idle_thr     = RST_IDLE_THR;
      target       = RST_TARGET;
      warn_min     = RST_WARN_MIN;
      danger_min   = RST_DANGER_MIN;
      vent_ms      = RST_VENT_MS;
      buzz_ms      = RST_BUZZ_MS;
      seated       = 1'b0;
      seat_start   = '0;
      cur_mode     = MODE_IDLE;
      buzz_phase   = 1'b0;
      buzz_stamp   = '0;
      refilling    = 1'b0;
      danger_stamp = '0;
      buzz_latch   = 1'b0;
      beats_seen   = 0;
      failures     = 0;
    endfunction

    // Register writes keep only the bits of the register's width.
    function void write_reg(cfg_idx_t idx, cfg_data_t val);
      case (idx)
        CFG_SIT_THR:    sit_thr    = val[ADC_W-1:0];
        CFG_IDLE_THR:   idle_thr   = val[ADC_W-1:0];
        CFG_TARGET:     target     = val[ADC_W-1:0];
        CFG_WARN_MIN:   warn_min   = val[7:0];
        CFG_DANGER_MIN: danger_min = val[7:0];
        CFG_VENT_MS:    vent_ms    = val;
        CFG_BUZZ_MS:    buzz_ms    = val;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return status_due.size();
    endfunction

    // Work out the status of one accepted sample beat and queue it.
    function void note_reading(reading_t r);
      adc_t        peak;
      ms_t         elapsed;
      int unsigned mins;
      bit          sit_now, low_press, pump, valve;
      status_t     want;
      peak = '0;
      for (int i = 0; i < 6; i++)
        if (r.lane[i] > peak) peak = r.lane[i];

      // Continuous sitting time, in whole minutes.
      sit_now = peak >= sit_thr;
      mins = 0;
      if (sit_now) begin
        if (!seated) begin
          seat_start = r.now;
          seated = 1'b1;
        end
        elapsed = r.now - seat_start;
        mins = elapsed / MS_PER_MINUTE;
      end else begin
        seated = 1'b0;
      end

      // Classification; danger is tested before warning.
      if (peak < idle_thr) begin
        cur_mode = MODE_IDLE;
      end else if (sit_now && mins >= danger_min) begin
        if (cur_mode != MODE_DANGER) begin
          cur_mode = MODE_DANGER;
          refilling = 1'b0;
          danger_stamp = r.now;
        end
      end else if (sit_now && mins >= warn_min) begin
        cur_mode = MODE_WARNING;
      end else begin
        cur_mode = MODE_NORMAL;
      end

      // Buzzer latch.
      if (cur_mode == MODE_WARNING) begin
        elapsed = r.now - buzz_stamp;
        if (elapsed >= buzz_ms) begin
          buzz_stamp = r.now;
          buzz_phase = !buzz_phase;
          buzz_latch = buzz_phase;
        end
      end else begin
        buzz_latch = cur_mode == MODE_DANGER;
      end

      // Pump and valve; a phase change shows from the next beat on.
      low_press = r.pressure < target;
      pump = 1'b0;
      valve = 1'b0;
      if (cur_mode == MODE_WARNING) begin
        pump = low_press;
      end else if (cur_mode == MODE_DANGER) begin
        if (!refilling) begin
          valve = 1'b1;
          elapsed = r.now - danger_stamp;
          if (elapsed >= vent_ms) begin
            refilling = 1'b1;
            danger_stamp = r.now;
          end
        end else if (low_press) begin
          pump = 1'b1;
        end else begin
          refilling = 1'b0;
          danger_stamp = r.now;
        end
      end

      want.mode    = cur_mode;
      want.pump    = pump;
      want.valve   = valve;
      want.buzz    = buzz_latch;
      want.minutes = mins[MIN_W-1:0];
      want.peak    = peak;
      status_due.push_back(want);
    endfunction

    // Prints one line per mismatch and counts it.
    task report(string msg);
      failures++;
      $display("MISMATCH: %s", msg);
    endtask

    // Compare one status beat with the oldest prediction.
    task check_status(status_t got);
      status_t want;
      beats_seen++;
      if (status_due.size() == 0) begin
        report($sformatf("status beat %0d arrived with no sample pending", beats_seen));
        return;
      end
      want = status_due.pop_front();
      if (got.mode !== want.mode)
        report($sformatf("beat %0d mode %0d, want %0d", beats_seen, got.mode, want.mode));
      if (got.pump !== want.pump)
        report($sformatf("beat %0d pump_on %b, want %b", beats_seen, got.pump, want.pump));
      if (got.valve !== want.valve)
        report($sformatf("beat %0d valve_open %b, want %b", beats_seen, got.valve,
                         want.valve));
      if (got.buzz !== want.buzz)
        report($sformatf("beat %0d buzzer_on %b, want %b", beats_seen, got.buzz, want.buzz));
      if (got.minutes !== want.minutes)
        report($sformatf("beat %0d sit_minutes %0d, want %0d", beats_seen, got.minutes,
                         want.minutes));
      if (got.peak !== want.peak)
        report($sformatf("beat %0d peak_force %0d, want %0d", beats_seen, got.peak,
                         want.peak));
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_data;
  bit        gaps_on;
  ms_t       clock_ms;

  sprc_sample_if sensor_ch ();
  sprc_status_if status_ch ();

  relief_status_tracker tracker = new();

  seat_pressure_relief_controller dut (
    .clk       (clk),
    .rst       (rst),
    .sensor    (sensor_ch),
    .status    (status_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Check every status beat taken at a clock edge.
  always @(posedge clk) begin : take_status
    status_t got;
    if (!rst && status_ch.valid && status_ch.ready) begin
      got.mode    = status_ch.mode;
      got.pump    = status_ch.pump_on;
      got.valve   = status_ch.valve_open;
      got.buzz    = status_ch.buzzer_on;
      got.minutes = status_ch.sit_minutes;
      got.peak    = status_ch.peak_force;
      tracker.check_status(got);
    end
  end

  // Status receiver: ready drops in random bursts while gaps are enabled.
  initial begin
    status_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (gaps_on && $urandom_range(0, 3) == 0) begin
        status_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        status_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // Hard limit on the run.
  initial begin
    #2000000;
    $display("seat_pressure_relief_controller regression: fail");
    $finish;
  end

  // Send one sample beat, possibly after a random gap, and note it once taken.
  task automatic send_reading(reading_t r);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      sensor_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    sensor_ch.valid            <= 1'b1;
    sensor_ch.force_a          <= r.lane[0];
    sensor_ch.force_b          <= r.lane[1];
    sensor_ch.force_c          <= r.lane[2];
    sensor_ch.force_d          <= r.lane[3];
    sensor_ch.force_e          <= r.lane[4];
    sensor_ch.force_f          <= r.lane[5];
    sensor_ch.pressure_reading <= r.pressure;
    sensor_ch.now_ms           <= r.now;
    @(posedge clk);
    while (!sensor_ch.ready) @(posedge clk);
    tracker.note_reading(r);
  endtask

  // Hold the sender off until every predicted status beat has come back.
  task automatic drain();
    sensor_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    tracker.write_reg(idx, val);
  endtask

  // Write all registers; unused upper data bits carry junk that must be dropped.
  task automatic apply_settings(adc_t sit, adc_t idle, adc_t tgt, min_cnt_t warn,
                                min_cnt_t danger, ms16_t vent, ms16_t buzz);
    cfg_data_t junk;
    junk = cfg_data_t'($urandom());
    write_reg(CFG_SIT_THR,    {junk[15:10], sit});
    write_reg(CFG_IDLE_THR,   {junk[9:4], idle});
    write_reg(CFG_TARGET,     {junk[5:0], tgt});
    write_reg(CFG_UNUSED,     cfg_data_t'($urandom()));
    write_reg(CFG_WARN_MIN,   {junk[15:8], warn});
    write_reg(CFG_DANGER_MIN, {junk[7:0], danger});
    write_reg(CFG_VENT_MS,    vent);
    write_reg(CFG_BUZZ_MS,    buzz);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic reading_t one_lane(int lane_idx, adc_t level, adc_t pres, ms_t t);
    reading_t r;
    r = '0;
    r.lane[lane_idx] = level;
    r.pressure = pres;
    r.now = t;
    return r;
  endfunction

  // Pressure mostly on either side of the target, sometimes anywhere.
  function automatic adc_t pick_pressure();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 9 && tracker.target != 0)
      return adc_t'($urandom_range(0, tracker.target - 1));
    if (roll < 18) return adc_t'($urandom_range(tracker.target, 1023));
    return adc_t'($urandom_range(0, 1023));
  endfunction

  // Time between samples: short steps for the buzzer and vent timers,
  // long steps scaled to the minute thresholds, rarely a jump anywhere.
  function automatic ms_t time_step();
    int unsigned roll, longest;
    roll = $urandom_range(0, 19);
    longest = (tracker.warn_min > tracker.danger_min) ? 32'(tracker.warn_min)
                                                      : 32'(tracker.danger_min);
    if (roll < 10) return $urandom_range(0, tracker.vent_ms + tracker.buzz_ms + 200);
    if (roll < 19) return $urandom_range(0, (longest + 2) * (MS_PER_MINUTE / 4));
    return $urandom();
  endfunction

  // Random sessions: mostly sitting stretches, some empty seat, some noise.
  task automatic run_random(int unsigned count);
    int unsigned sent, len, kind;
    adc_t        peak_lvl, floor_lvl;
    reading_t    r;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 9);
      len = (kind < 7) ? $urandom_range(4, 60) : $urandom_range(1, 8);
      for (int unsigned k = 0; k < len && sent < count; k++) begin
        clock_ms += time_step();
        if (kind < 7 && $urandom_range(0, 19) != 0) begin
          floor_lvl = (tracker.idle_thr > tracker.sit_thr) ? tracker.idle_thr
                                                           : tracker.sit_thr;
          peak_lvl = adc_t'($urandom_range(0, 1) ? $urandom_range(tracker.sit_thr, 1023)
                                                 : $urandom_range(floor_lvl, 1023));
          for (int i = 0; i < 6; i++) r.lane[i] = adc_t'($urandom_range(0, peak_lvl));
          r.lane[$urandom_range(0, 5)] = peak_lvl;
        end else if (kind < 9) begin
          for (int i = 0; i < 6; i++)
            r.lane[i] = (tracker.sit_thr == 0) ? '0
                        : adc_t'($urandom_range(0, tracker.sit_thr - 1));
        end else begin
          for (int i = 0; i < 6; i++) r.lane[i] = adc_t'($urandom_range(0, 1023));
          clock_ms = $urandom();
        end
        r.pressure = pick_pressure();
        r.now = clock_ms;
        send_reading(r);
        sent++;
      end
    end
  endtask

  // Main sequence.
  initial begin
    rst                        <= 1'b1;
    cfg_we                     <= 1'b0;
    cfg_index                  <= CFG_SIT_THR;
    cfg_data                   <= '0;
    sensor_ch.valid            <= 1'b0;
    sensor_ch.force_a          <= '0;
    sensor_ch.force_b          <= '0;
    sensor_ch.force_c          <= '0;
    sensor_ch.force_d          <= '0;
    sensor_ch.force_e          <= '0;
    sensor_ch.force_f          <= '0;
    sensor_ch.pressure_reading <= '0;
    sensor_ch.now_ms           <= '0;
    gaps_on                    = 1'b1;
    clock_ms                   = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed walk with reset settings: thresholds at their edges, warning
    // buzzer toggles, a full vent and refill cycle, then timestamp wrap.
    send_reading(one_lane(0, 10'd0, 10'd0, 32'd1000));
    send_reading(one_lane(0, 10'd272, 10'd1023, 32'd1100));
    send_reading(one_lane(1, 10'd273, 10'd500, 32'd1200));
    send_reading(one_lane(2, 10'd596, 10'd500, 32'd1300));
    send_reading(one_lane(3, 10'd597, 10'd500, 32'd1400));
    send_reading(one_lane(4, 10'd1023, 10'd108, 32'd61200));
    send_reading(one_lane(5, 10'd1023, 10'd109, 32'd61300));
    send_reading(one_lane(0, 10'd800, 10'd0, 32'd61700));
    send_reading(one_lane(1, 10'd800, 10'd0, 32'd241200));
    send_reading(one_lane(2, 10'd800, 10'd0, 32'd246199));
    send_reading(one_lane(3, 10'd800, 10'd0, 32'd246200));
    send_reading(one_lane(4, 10'd800, 10'd50, 32'd246300));
    send_reading(one_lane(5, 10'd800, 10'd109, 32'd246400));
    send_reading(one_lane(0, 10'd800, 10'd1023, 32'd246500));
    send_reading(one_lane(0, 10'd0, 10'd1023, 32'd246600));
    send_reading('{lane: {6{10'd1023}}, pressure: 10'd1023, now: 32'hFFFF_FF00});
    send_reading('{lane: {6{10'd1023}}, pressure: 10'd0, now: 32'h0000_EA00});
    send_reading('{lane: {6{10'd1023}}, pressure: 10'd0, now: 32'hFFFF_FEFF});
    send_reading(one_lane(5, 10'd0, 10'd0, 32'd0));
    run_random(300);
    drain();

    // Moderate random settings, with a full hold-off halfway through.
    apply_settings(adc_t'($urandom_range(100, 600)), adc_t'($urandom_range(300, 900)),
                   adc_t'($urandom_range(0, 1023)), min_cnt_t'($urandom_range(0, 5)),
                   min_cnt_t'($urandom_range(0, 8)), ms16_t'($urandom_range(0, 20000)),
                   ms16_t'($urandom_range(0, 3000)));
    run_random(160);
    drain();
    run_random(160);
    drain();

    // Everything zero: always seated, never idle, danger at once, zero timers.
    apply_settings('0, '0, '0, '0, '0, '0, '0);
    run_random(300);
    drain();

    // Everything at its maximum.
    apply_settings(10'd1023, 10'd1023, 10'd1023, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF);
    run_random(330);
    drain();

    // Sit threshold above idle threshold, danger minutes below warning minutes.
    apply_settings(10'd800, 10'd400, 10'd512, 8'd6, 8'd2, 16'd0, 16'd0);
    run_random(330);
    drain();

    // Full-range random settings, with no idling on either side.
    apply_settings(adc_t'($urandom_range(0, 1023)), adc_t'($urandom_range(0, 1023)),
                   adc_t'($urandom_range(0, 1023)), min_cnt_t'($urandom_range(0, 255)),
                   min_cnt_t'($urandom_range(0, 255)), ms16_t'($urandom_range(0, 65535)),
                   ms16_t'($urandom_range(0, 65535)));
    gaps_on = 1'b0;
    run_random(370);
    drain();

    // Let any stray beat show up before the final verdict.
    repeat (20) @(posedge clk);
    if (tracker.pending() != 0)
      tracker.report($sformatf("%0d predicted status beats never arrived",
                               tracker.pending()));
    if (tracker.failures == 0)
      $display("seat_pressure_relief_controller regression: pass");
    else
      $display("seat_pressure_relief_controller regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sprc_pkg.sv
rtl/sprc_sample_if.sv
rtl/sprc_status_if.sv
rtl/sprc_lane.sv
rtl/sprc_peak.sv
rtl/sprc_minutes.sv
rtl/sprc_ctrl.sv
rtl/seat_pressure_relief_controller.sv
verif/tb_seat_pressure_relief_controller.sv
